FILE: rtl/sasf_pkg.sv
`timescale 1ns / 1ps
package sasf_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int CCNT_W      = 11;
	localparam int SCNT_W      = 16;
	localparam int GCNT_W      = 16;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	typedef enum logic [1:0] {
		REG_COLUMN_COUNT = 2'd0,
		REG_SAMPLE_COUNT = 2'd1,
		REG_GROUP_COUNT  = 2'd2
	} reg_idx_t;

	// Per-item bookkeeping that rides along the adder pipeline.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             last;
		logic             gdone;
		logic             jdone;
	} tag_t;

	// Register load strobes for the adder stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

	localparam logic [63:0] F64_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

endpackage

FILE: rtl/sasf_if.sv
`timescale 1ns / 1ps
interface sasf_in_if import sasf_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;

	modport source (output valid, output value_bits, input ready);
	modport sink (input valid, input value_bits, output ready);
endinterface

interface sasf_out_if import sasf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [63:0]      sum_bits;
	logic [COL_W-1:0] column_index;
	logic             group_done;
	logic             job_done;

	modport source (output valid, output sum_bits, output column_index, output group_done,
		output job_done, input ready);
	modport sink (input valid, input sum_bits, input column_index, input group_done,
		input job_done, output ready);
endinterface

FILE: rtl/sasf_fadd.sv
`timescale 1ns / 1ps
module sasf_fadd import sasf_pkg::*; (
	input  logic        clk,
	input  adv_t        adv,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] res
);

	function automatic logic [5:0] lzc57(input logic [56:0] v);
		logic [5:0] n;
		n = 6'd57;
		for (int i = 0; i < 57; i++) begin
			if (v[i]) begin
				n = 6'(56 - i);
			end
		end
		return n;
	endfunction

	// Stage 1: specials, operand swap and alignment.
	logic [10:0] a_exp, b_exp;
	logic        a_nan, b_nan, a_inf, b_inf, spec;
	logic [63:0] spec_res, big, sml;
	logic [10:0] eb, es, d;
	logic [52:0] mb, ms;
	logic [55:0] ext, shifted, mask, al;
	logic [5:0]  sh;

	always_comb begin
		a_exp = a[62:52];
		b_exp = b[62:52];
		a_nan = (&a_exp) && (|a[51:0]);
		b_nan = (&b_exp) && (|b[51:0]);
		a_inf = (&a_exp) && !(|a[51:0]);
		b_inf = (&b_exp) && !(|b[51:0]);
		spec  = a_nan || b_nan || a_inf || b_inf;
		if (a_nan) begin
			spec_res = a | 64'h0008_0000_0000_0000;
		end else if (b_nan) begin
			spec_res = b | 64'h0008_0000_0000_0000;
		end else if (a_inf && b_inf && (a[63] != b[63])) begin
			spec_res = F64_DEFAULT_NAN;
		end else if (a_inf) begin
			spec_res = a;
		end else begin
			spec_res = b;
		end
		if (a[62:0] >= b[62:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
		es = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
		mb = {|big[62:52], big[51:0]};
		ms = {|sml[62:52], sml[51:0]};
		d  = eb - es;
		sh = (d > 11'd56) ? 6'd56 : d[5:0];
		ext     = {ms, 3'b000};
		shifted = ext >> sh;
		mask    = (56'd1 << sh) - 56'd1;
		al      = {shifted[55:1], shifted[0] | (|(ext & mask))};
	end

	logic        sign_s2, sub_s2, spec_s2;
	logic [10:0] e_s2;
	logic [55:0] mb_s2, al_s2;
	logic [63:0] spec_res_s2;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			sign_s2     <= big[63];
			sub_s2      <= a[63] ^ b[63];
			spec_s2     <= spec;
			spec_res_s2 <= spec_res;
			e_s2        <= eb;
			mb_s2       <= {mb, 3'b000};
			al_s2       <= al;
		end
	end

	// Stage 2: magnitude add or subtract; the big operand never falls below the small one.
	logic        sign_s3, sub_s3, spec_s3;
	logic [10:0] e_s3;
	logic [56:0] sum_s3;
	logic [63:0] spec_res_s3;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sign_s3     <= sign_s2;
			sub_s3      <= sub_s2;
			spec_s3     <= spec_s2;
			spec_res_s3 <= spec_res_s2;
			e_s3        <= e_s2;
			sum_s3      <= sub_s2 ? ({1'b0, mb_s2} - {1'b0, al_s2}) : ({1'b0, mb_s2} + {1'b0, al_s2});
		end
	end

	// Stage 3: leading zero count.
	logic        sign_s4, zero_s4, spec_s4;
	logic [10:0] e_s4;
	logic [56:0] sum_s4;
	logic [5:0]  lz_s4;
	logic [63:0] spec_res_s4;

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			// An exact cancellation rounds to +0; two zeros of one sign keep it.
			sign_s4     <= (sum_s3 == 57'd0 && sub_s3) ? 1'b0 : sign_s3;
			zero_s4     <= (sum_s3 == 57'd0);
			spec_s4     <= spec_s3;
			spec_res_s4 <= spec_res_s3;
			e_s4        <= e_s3;
			sum_s4      <= sum_s3;
			lz_s4       <= lzc57(sum_s3);
		end
	end

	// Stage 4: normalize, stopping at the subnormal exponent.
	logic [5:0]  lzm1, shl;
	logic [10:0] em1;
	logic [55:0] norm;
	logic [11:0] e_n;

	always_comb begin
		lzm1 = lz_s4 - 6'd1;
		em1  = e_s4 - 11'd1;
		shl  = ({5'd0, lzm1} < em1) ? lzm1 : em1[5:0];
		if (sum_s4[56]) begin
			norm = {sum_s4[56:2], sum_s4[1] | sum_s4[0]};
			e_n  = {1'b0, e_s4} + 12'd1;
		end else begin
			norm = sum_s4[55:0] << shl;
			e_n  = {1'b0, e_s4} - {6'd0, shl};
		end
	end

	logic        sign_s5, zero_s5, spec_s5;
	logic [11:0] e_s5;
	logic [55:0] norm_s5;
	logic [63:0] spec_res_s5;

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			sign_s5     <= sign_s4;
			zero_s5     <= zero_s4;
			spec_s5     <= spec_s4;
			spec_res_s5 <= spec_res_s4;
			e_s5        <= e_n;
			norm_s5     <= norm;
		end
	end

	// Stage 5: round to nearest even; a mantissa carry runs into the exponent field.
	logic [10:0] ef;
	logic        up;
	logic [62:0] packed_mag;

	always_comb begin
		ef         = norm_s5[55] ? e_s5[10:0] : 11'd0;
		up         = norm_s5[2] & (norm_s5[1] | norm_s5[0] | norm_s5[3]);
		packed_mag = {ef, norm_s5[54:3]} + {62'd0, up};
		if (spec_s5) begin
			res = spec_res_s5;
		end else if (zero_s5) begin
			res = {sign_s5, 63'd0};
		end else if (e_s5 >= 12'd2047) begin
			res = {sign_s5, 11'h7FF, 52'd0};
		end else begin
			res = {sign_s5, packed_mag};
		end
	end

endmodule

FILE: rtl/strided_axis_sum_f64.sv
`timescale 1ns / 1ps
// An accepted input beat runs through pipeline stages 1 to 5 to its result on the output register.
// Throughput, with no output stall: one beat per cycle while column_count is 6 or more. An
// element not of the first sample of a group waits while an earlier element of its column is
// still in the five pipeline stages ahead of the accumulator write, so fewer columns lower the rate.
// Reset clears counters and valids and sets count registers to one; the accumulator is not cleared.
module strided_axis_sum_f64 import sasf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	sasf_in_if.sink            elem,
	sasf_out_if.source         result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CCNT_W-1:0] ccnt_q;
	logic [SCNT_W-1:0] scnt_q;
	logic [GCNT_W-1:0] gcnt_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && (cfg_idx == REG_COLUMN_COUNT ||
		cfg_idx == REG_SAMPLE_COUNT || cfg_idx == REG_GROUP_COUNT);

	always_comb begin
		case (cfg_idx)
			REG_COLUMN_COUNT: prdata = {{(PDATA_W-CCNT_W){1'b0}}, ccnt_q};
			REG_SAMPLE_COUNT: prdata = {{(PDATA_W-SCNT_W){1'b0}}, scnt_q};
			REG_GROUP_COUNT:  prdata = {{(PDATA_W-GCNT_W){1'b0}}, gcnt_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccnt_q <= CCNT_W'(1);
			scnt_q <= SCNT_W'(1);
			gcnt_q <= GCNT_W'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_COLUMN_COUNT: ccnt_q <= pwdata[CCNT_W-1:0];
				REG_SAMPLE_COUNT: scnt_q <= pwdata[SCNT_W-1:0];
				REG_GROUP_COUNT:  gcnt_q <= pwdata[GCNT_W-1:0];
				default:          ccnt_q <= ccnt_q;
			endcase
		end
	end

	// Effective counts: zero acts as one, columns are capped at the memory depth.
	logic [CCNT_W-1:0] cols;
	logic [SCNT_W-1:0] samps;
	logic [GCNT_W-1:0] groups;

	always_comb begin
		if (ccnt_q == '0) begin
			cols = CCNT_W'(1);
		end else if (ccnt_q > CCNT_W'(MAX_COLUMNS)) begin
			cols = CCNT_W'(MAX_COLUMNS);
		end else begin
			cols = ccnt_q;
		end
		samps  = (scnt_q == '0) ? SCNT_W'(1) : scnt_q;
		groups = (gcnt_q == '0) ? GCNT_W'(1) : gcnt_q;
	end

	// Position counters.
	logic [COL_W-1:0]  col_q;
	logic [SCNT_W-1:0] samp_q;
	logic [GCNT_W-1:0] grp_q;
	logic              last_col, last_samp, last_grp, first, accept;
	tag_t              tag_in;

	assign last_col  = ({{(CCNT_W-COL_W){1'b0}}, col_q} + CCNT_W'(1)) >= cols;
	assign last_samp = ({1'b0, samp_q} + 17'd1) >= {1'b0, samps};
	assign last_grp  = ({1'b0, grp_q} + 17'd1) >= {1'b0, groups};
	assign first     = (samp_q == '0);
	assign tag_in    = '{col: col_q, last: last_samp, gdone: last_col,
		jdone: last_col && last_grp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			samp_q <= '0;
			grp_q  <= '0;
		end else if (cfg_wr) begin
			col_q  <= '0;
			samp_q <= '0;
			grp_q  <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_samp) begin
					samp_q <= '0;
					grp_q  <= last_grp ? '0 : grp_q + GCNT_W'(1);
				end else begin
					samp_q <= samp_q + SCNT_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Pipeline control: stage 1 holds the memory read, stages 2 to 5 the adder.
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic first_s1;
	logic [63:0] x_s1, rdata_s1, acc_op, sum;
	logic leave5, free5, free4, free3, free2, free1;
	logic ld2, ld3, ld4, ld5, hazard;
	logic out_v_q;
	adv_t adv;

	assign leave5 = v5_q && (!tag_s5.last || !out_v_q || result.ready);
	assign free5  = !v5_q || leave5;
	assign ld5    = v4_q && free5;
	assign free4  = !v4_q || ld5;
	assign ld4    = v3_q && free4;
	assign free3  = !v3_q || ld4;
	assign ld3    = v2_q && free3;
	assign free2  = !v2_q || ld3;
	assign ld2    = v1_q && free2;
	assign free1  = !v1_q || ld2;

	// A read of a column whose newer sum has not reached the memory must wait.
	assign hazard = !first && ((v1_q && tag_s1.col == col_q) || (v2_q && tag_s2.col == col_q) ||
		(v3_q && tag_s3.col == col_q) || (v4_q && tag_s4.col == col_q) ||
		(v5_q && tag_s5.col == col_q));

	assign elem.ready = free1 && !hazard;
	assign accept     = elem.valid && elem.ready;
	assign adv        = '{s2: ld2, s3: ld3, s4: ld4, s5: ld5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			v1_q <= accept || (v1_q && !ld2);
			v2_q <= ld2 || (v2_q && !ld3);
			v3_q <= ld3 || (v3_q && !ld4);
			v4_q <= ld4 || (v4_q && !ld5);
			v5_q <= ld5 || (v5_q && !leave5);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1   <= tag_in;
			first_s1 <= first;
			x_s1     <= elem.value_bits;
		end
		if (ld2) begin
			tag_s2 <= tag_s1;
		end
		if (ld3) begin
			tag_s3 <= tag_s2;
		end
		if (ld4) begin
			tag_s4 <= tag_s3;
		end
		if (ld5) begin
			tag_s5 <= tag_s4;
		end
	end

	// Accumulator memory, one entry per column.
	logic [63:0] sums_mem [MAX_COLUMNS];

	always_ff @(posedge clk) begin
		if (leave5) begin
			sums_mem[tag_s5.col] <= sum;
		end
		if (accept) begin
			rdata_s1 <= sums_mem[col_q];
		end
	end

	assign acc_op = first_s1 ? 64'd0 : rdata_s1;

	sasf_fadd u_fadd (
		.clk (clk),
		.adv (adv),
		.a   (acc_op),
		.b   (x_s1),
		.res (sum)
	);

	// Output register.
	logic [63:0]      out_sum_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_gdone_q, out_jdone_q, out_ld;

	assign out_ld = leave5 && tag_s5.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_ld) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_sum_q   <= sum;
			out_col_q   <= tag_s5.col;
			out_gdone_q <= tag_s5.gdone;
			out_jdone_q <= tag_s5.jdone;
		end
	end

	assign result.valid        = out_v_q;
	assign result.sum_bits     = out_sum_q;
	assign result.column_index = out_col_q;
	assign result.group_done   = out_gdone_q;
	assign result.job_done     = out_jdone_q;

`ifndef SYNTHESIS
	a_job_ends_group: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.job_done |-> result.group_done)
		else $error("job end without group end");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> {{(CCNT_W-COL_W){1'b0}}, result.column_index} < cols)
		else $error("result column beyond column count");

	a_no_raw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(v1_q && !first_s1 && v5_q && tag_s1.col == tag_s5.col))
		else $error("accumulator read overlaps an unwritten sum");

	a_s5_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v5_q && !leave5 |=> v5_q && $stable(tag_s5.col))
		else $error("stalled adder result lost");
`endif

endmodule

FILE: verif/tb_strided_axis_sum_f64.sv
`timescale 1ns / 1ps
module tb_strided_axis_sum_f64;
	import sasf_pkg::*;

	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [63:0] F64_QUIET_BIT = 64'h0008_0000_0000_0000;

	typedef struct {
		logic [63:0]      sum_bits;
		logic [COL_W-1:0] column_index;
		logic             group_done;
		logic             job_done;
	} column_sum_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	sasf_in_if elem_ch ();
	sasf_out_if sum_ch ();

	strided_axis_sum_f64 dut (
		.clk(clk),
		.arst_n(arst_n),
		.elem(elem_ch),
		.result(sum_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mirror of the block's registers and accumulators.
	logic [CCNT_W-1:0] cols_reg = CCNT_W'(1);
	logic [SCNT_W-1:0] samps_reg = SCNT_W'(1);
	logic [GCNT_W-1:0] groups_reg = GCNT_W'(1);
	logic [63:0] col_acc [MAX_COLUMNS];
	int unsigned col_pos, samp_pos, grp_pos;
	column_sum_t sums_pending[$];

	int errors = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int quiet_cycles = 0;

	function automatic bit is_nan(logic [63:0] b);
		return b[62:52] == 11'h7FF && b[51:0] != 0;
	endfunction

	// Binary64 add with x86-style NaN rules: the first NaN operand wins, quieted.
	function automatic logic [63:0] f64_add(logic [63:0] a, logic [63:0] b);
		if (is_nan(a)) begin
			return a | F64_QUIET_BIT;
		end
		if (is_nan(b)) begin
			return b | F64_QUIET_BIT;
		end
		if (a[62:0] == 63'h7FF0_0000_0000_0000 && b[62:0] == 63'h7FF0_0000_0000_0000
				&& a[63] != b[63]) begin
			return F64_DEFAULT_NAN;
		end
		return $realtobits($bitstoreal(a) + $bitstoreal(b));
	endfunction

	function automatic int unsigned eff_count(int unsigned v, int unsigned cap);
		if (v == 0) begin
			return 1;
		end
		return (v > cap) ? cap : v;
	endfunction

	function automatic void accumulate_element(logic [63:0] v);
		int unsigned cols, samps, groups, col;
		logic [63:0] acc;
		column_sum_t s;
		cols = eff_count(32'(cols_reg), MAX_COLUMNS);
		samps = eff_count(32'(samps_reg), 65535);
		groups = eff_count(32'(groups_reg), 65535);
		col = (col_pos >= cols) ? 0 : col_pos;
		acc = f64_add((samp_pos == 0) ? 64'h0 : col_acc[col], v);
		col_acc[col] = acc;
		if (samp_pos + 1 >= samps) begin
			s.sum_bits = acc;
			s.column_index = col[COL_W-1:0];
			s.group_done = (col + 1 >= cols);
			s.job_done = s.group_done && (grp_pos + 1 >= groups);
			sums_pending.push_back(s);
		end
		col++;
		if (col >= cols) begin
			col = 0;
			samp_pos++;
			if (samp_pos >= samps) begin
				samp_pos = 0;
				grp_pos++;
				if (grp_pos >= groups) begin
					grp_pos = 0;
				end
			end
		end
		col_pos = col;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(negedge clk) begin
		sum_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin
		column_sum_t e;
		if (arst_n && sum_ch.valid && sum_ch.ready) begin
			if (sums_pending.size() == 0) begin
				report_mismatch("unexpected sum beat", sum_ch.sum_bits, 64'h0);
			end else begin
				e = sums_pending.pop_front();
				if (sum_ch.sum_bits !== e.sum_bits)
					report_mismatch("sum_bits", sum_ch.sum_bits, e.sum_bits);
				if (sum_ch.column_index !== e.column_index)
					report_mismatch("column_index", 64'(sum_ch.column_index),
						64'(e.column_index));
				if (sum_ch.group_done !== e.group_done)
					report_mismatch("group_done", 64'(sum_ch.group_done), 64'(e.group_done));
				if (sum_ch.job_done !== e.job_done)
					report_mismatch("job_done", 64'(sum_ch.job_done), 64'(e.job_done));
			end
		end
	end

	always @(posedge clk) begin
		if ((elem_ch.valid && elem_ch.ready) || (sum_ch.valid && sum_ch.ready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired at %0t", $realtime);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// All tasks below start and end at a falling edge.
	task automatic send_element(logic [63:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			elem_ch.valid <= 1'b0;
			@(negedge clk);
		end
		elem_ch.valid <= 1'b1;
		elem_ch.value_bits <= v;
		do @(posedge clk); while (!elem_ch.ready);
		accumulate_element(v);
		@(negedge clk);
	endtask

	// Waits out every pending sum, then the pipeline depth for elements with no sum.
	task automatic wait_idle();
		elem_ch.valid <= 1'b0;
		while (sums_pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		wait_idle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_COLUMN_COUNT: cols_reg = data[CCNT_W-1:0];
			REG_SAMPLE_COUNT: samps_reg = data[SCNT_W-1:0];
			REG_GROUP_COUNT: groups_reg = data[GCNT_W-1:0];
			default: return;
		endcase
		col_pos = 0;
		samp_pos = 0;
		grp_pos = 0;
	endtask

	task automatic check_reg(logic [1:0] idx, logic [31:0] want);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch("register readback", 64'(prdata), 64'(want));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(int unsigned cols, int unsigned samps, int unsigned groups);
		write_reg(REG_COLUMN_COUNT, cols);
		write_reg(REG_SAMPLE_COUNT, samps);
		write_reg(REG_GROUP_COUNT, groups);
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] r;
		logic [63:0] specials [10] = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
			64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001, 64'hFFF8_0000_0000_0000,
			64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000,
			64'hFFFF_FFFF_FFFF_FFFF};
		r = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2: return r;
			3, 4, 5: return $realtobits(real'($signed($urandom_range(2000)) - 1000) / 8.0);
			6: return specials[$urandom_range(9)];
			7: return {r[63], 11'h000, r[51:0]};
			8: return {r[63], 11'h7FE - 11'($urandom_range(3)), r[51:0]};
			default: return {r[63], 11'd1023 - 11'd60 + 11'($urandom_range(120)), r[51:0]};
		endcase
	endfunction

	task automatic test_single_elements();
		logic [63:0] vals [9] = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0001,
			64'hFFF8_0000_0000_1234, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
			64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF};
		check_reg(REG_COLUMN_COUNT, 1);
		check_reg(REG_SAMPLE_COUNT, 1);
		check_reg(REG_GROUP_COUNT, 1);
		foreach (vals[i])
			send_element(vals[i]);
	endtask

	task automatic test_special_sums();
		// Infinities that cancel, overflow, a rounding tie, and negative zeros.
		logic [63:0] vals [12] = '{
			64'h7FF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
			64'hFFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
			64'h3FF0_0000_0000_0000, 64'hFFEF_FFFF_FFFF_FFFF,
			64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h3CA0_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h3CA0_0000_0000_0000, 64'h8000_0000_0000_0000};
		configure(2, 3, 2);
		foreach (vals[i])
			send_element(vals[i]);
	endtask

	task automatic test_zero_counts();
		configure(0, 0, 0);
		check_reg(REG_COLUMN_COUNT, 0);
		check_reg(REG_SAMPLE_COUNT, 0);
		check_reg(REG_GROUP_COUNT, 0);
		repeat (2) send_element(random_value());
	endtask

	task automatic test_register_writes();
		write_reg(REG_COLUMN_COUNT, 32'hFFFF_F803);
		check_reg(REG_COLUMN_COUNT, 3);
		write_reg(REG_SAMPLE_COUNT, 2);
		write_reg(REG_GROUP_COUNT, 1);
		repeat (2) send_element(random_value());
		// An unmapped write must not restart the job in progress.
		write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
		repeat (4) send_element(random_value());
		// A mapped write, here at a job boundary, resets the position counters.
		write_reg(REG_SAMPLE_COUNT, 2);
		repeat (6) send_element(random_value());
	endtask

	task automatic test_extreme_counts();
		configure(2047, 1, 1);
		check_reg(REG_COLUMN_COUNT, 2047);
		repeat (MAX_COLUMNS + 1) send_element(random_value());
		configure(1, 65535, 65535);
		check_reg(REG_SAMPLE_COUNT, 65535);
		check_reg(REG_GROUP_COUNT, 65535);
		repeat (5) send_element(random_value());
		configure(3, 1, 65535);
		repeat (12) send_element(random_value());
	endtask

	task automatic test_random_jobs(int n, int snd_pct, int rcv_pct);
		int sent;
		int unsigned cols, samps, groups, job_len;
		sent = 0;
		sender_idle_pct = snd_pct;
		receiver_idle_pct = rcv_pct;
		while (sent < n) begin
			case ($urandom_range(9))
				0: cols = 0;
				1, 2: cols = $urandom_range(40, 6);
				default: cols = $urandom_range(7, 1);
			endcase
			case ($urandom_range(9))
				0: samps = 0;
				1: samps = 65535;
				default: samps = $urandom_range(5, 1);
			endcase
			case ($urandom_range(9))
				0: groups = 0;
				1: groups = 65535;
				default: groups = $urandom_range(3, 1);
			endcase
			configure(cols, samps, groups);
			job_len = eff_count(cols, MAX_COLUMNS) * eff_count(samps, 65535)
				* eff_count(groups, 65535);
			if (job_len > 300) begin
				job_len = $urandom_range(300, 1);
			end else if ($urandom_range(9) == 0) begin
				job_len = $urandom_range(job_len, 1);
			end else if ($urandom_range(9) == 0) begin
				job_len = job_len * 2;
			end
			repeat (job_len) send_element(random_value());
			sent += job_len;
		end
		wait_idle();
	endtask

	initial begin
		elem_ch.valid = 1'b0;
		elem_ch.value_bits = '0;
		sum_ch.ready = 1'b0;
		foreach (col_acc[i])
			col_acc[i] = '0;
		col_pos = 0;
		samp_pos = 0;
		grp_pos = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		sender_idle_pct = 12;
		receiver_idle_pct = 45;
		test_single_elements();
		test_special_sums();
		test_zero_counts();
		test_register_writes();
		test_random_jobs(250, 12, 45);
		test_random_jobs(250, 45, 12);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		test_extreme_counts();
		test_random_jobs(150, 0, 0);

		wait_idle();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
